FILE: rtl/mseu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mseu_pkg;

  // Operation codes carried on the func field.
  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_ADDI = 5'd1,
    OP_AND  = 5'd2,
    OP_BEQ  = 5'd3,
    OP_BGTZ = 5'd4,
    OP_BLEZ = 5'd5,
    OP_BNE  = 5'd6,
    OP_DIV  = 5'd7,
    OP_J    = 5'd8,
    OP_JAL  = 5'd9,
    OP_JR   = 5'd10,
    OP_LUI  = 5'd11,
    OP_LW   = 5'd12,
    OP_MFHI = 5'd13,
    OP_MULT = 5'd14,
    OP_MFLO = 5'd15,
    OP_OR   = 5'd16,
    OP_SLL  = 5'd17,
    OP_ROTR = 5'd18,
    OP_SRL  = 5'd19,
    OP_SLT  = 5'd20,
    OP_SW   = 5'd21,
    OP_SUB  = 5'd22,
    OP_XOR  = 5'd23
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_DIV0  = 2'd1,
    STAT_ADDR  = 2'd2,
    STAT_BADOP = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDAB,
    ST_RDD,
    ST_EXEC,
    ST_MEMRD,
    ST_DIV,
    ST_DONE
  } state_t;

  localparam int unsigned WORD_BITS = 32;

endpackage

`default_nettype wire

FILE: rtl/mseu_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Signed truncating divider, one quotient bit per cycle on the magnitudes.
module mseu_div
  import mseu_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [WORD_BITS-1:0] dividend,
  input  wire logic [WORD_BITS-1:0] divisor,
  output logic                      done,
  output logic [WORD_BITS-1:0]      quotient,
  output logic [WORD_BITS-1:0]      remainder
);

  localparam int unsigned CW = $clog2(WORD_BITS);

  logic                 busy_r;
  logic                 done_r;
  logic [CW-1:0]        cnt_r;
  logic [WORD_BITS-1:0] rem_r;
  logic [WORD_BITS-1:0] quo_r;
  logic [WORD_BITS-1:0] dvs_r;
  logic                 negq_r;
  logic                 negr_r;
  logic [WORD_BITS:0]   rem_sh;
  logic [WORD_BITS:0]   diff;

  assign rem_sh = {rem_r, quo_r[WORD_BITS-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(WORD_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quo_r  <= dividend[WORD_BITS-1] ? -dividend : dividend;
      dvs_r  <= divisor[WORD_BITS-1] ? -divisor : divisor;
      negq_r <= dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
      negr_r <= dividend[WORD_BITS-1];
    end else if (busy_r) begin
      if (!diff[WORD_BITS]) begin
        rem_r <= diff[WORD_BITS-1:0];
        quo_r <= {quo_r[WORD_BITS-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[WORD_BITS-1:0];
        quo_r <= {quo_r[WORD_BITS-2:0], 1'b0};
      end
    end
  end

  assign done      = done_r;
  assign quotient  = negq_r ? -quo_r : quo_r;
  assign remainder = negr_r ? -rem_r : rem_r;

endmodule

`default_nettype wire

FILE: rtl/mips_subset_execute_unit_core.sv
`timescale 1ns / 1ps
`default_nettype none

// An accepted instruction passes through ST_RDAB, ST_RDD and ST_EXEC, then ST_MEMRD for an
// in-range LW, or ST_DIV for a DIV by a nonzero divisor, which waits for the 32 one-bit steps
// of the divider; ST_DONE loads the output register once it is free. One instruction is
// handled at a time; the register file read port pair serves the three operands in ST_RDAB
// and ST_RDD. Reset: synchronous, active low; afterwards the data memory is swept to zero one
// word a cycle; no instruction is accepted during the sweep.
module mips_subset_execute_unit_core
  import mseu_pkg::*;
#(
  parameter int unsigned MEM_WORDS  = 1024,
  parameter int unsigned INDEX_BITS = 16,
  parameter int unsigned RETURN_REG = 31
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [4:0]         in_func,
  input  wire logic [4:0]         in_dest_reg,
  input  wire logic [4:0]         in_src_a,
  input  wire logic [4:0]         in_src_b,
  input  wire logic signed [15:0] in_immediate,
  input  wire logic [4:0]         in_shift_amount,
  input  wire logic [15:0]        in_jump_target,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [15:0]             out_next_index,
  output logic [1:0]              out_status,
  output logic                    out_reg_written,
  output logic [4:0]              out_written_reg,
  output logic signed [31:0]      out_written_value,
  output logic                    out_mem_written,
  output logic [9:0]              out_mem_address
);

  localparam int unsigned AW = $clog2(MEM_WORDS);
  localparam int unsigned IB = INDEX_BITS;

  // Sequencer state and the instruction held while it executes.
  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_r;
  op_t             op_r;
  logic [4:0]      rd_r, ra_r, rb_r, sh_r;
  logic [15:0]     imm_r, tgt_r;
  logic [31:0]     va_r, vb_r;
  logic [IB-1:0]   idx_r;
  logic [31:0]     hi_r, lo_r;

  // Register file: a memory with two registered read ports; valid bits stand in for the
  // reset to zero, so an entry never written reads as zero.
  logic [31:0]     rf [32];
  logic [31:0]     rf_vld_r;
  logic [4:0]      rf_a0, rf_a1;
  logic [31:0]     rd0_q, rd1_q;
  logic            rf_we;
  logic [4:0]      rf_wa;
  logic [31:0]     rf_wd;

  // Data memory with one registered read port and one write port.
  logic [31:0]     dm [MEM_WORDS];
  logic [31:0]     dm_q;
  logic            dm_we, dm_re;
  logic [AW-1:0]   dm_wa;
  logic [31:0]     dm_wd;

  // Execute stage results.
  logic [31:0]     imm32;
  logic [32:0]     addr33;
  logic            addr_ok;
  logic [IB-1:0]   idx_inc;
  logic [IB-1:0]   ex_next;
  status_t         ex_status;
  logic            ex_wr, ex_mw, taken;
  logic [4:0]      ex_wreg;
  logic [31:0]     ex_wval;
  logic [9:0]      ex_maddr;
  logic [63:0]     prod;
  logic [63:0]     rot;

  // Result waiting in the execute side, then in the output register.
  logic [15:0]     res_next_r;
  status_t         res_status_r;
  logic            res_wr_r, res_mw_r;
  logic [4:0]      res_wreg_r;
  logic [31:0]     res_wval_r;
  logic [9:0]      res_maddr_r;
  logic            out_valid_r;
  logic            out_load;

  logic            div_start, div_done;
  logic [31:0]     div_q, div_r;

  mseu_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (rd0_q),
    .divisor   (va_r),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == AW'(MEM_WORDS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_RDAB;
      ST_RDAB:  state_nxt = ST_RDD;
      ST_RDD:   state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (op_r == OP_LW && addr_ok) begin
          state_nxt = ST_MEMRD;
        end else if (op_r == OP_DIV && va_r != '0) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_MEMRD: state_nxt = ST_DONE;
      ST_DIV:   if (div_done) state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, port addresses and unit strobes.
  always_comb begin
    in_stall  = 1'b1;
    rf_a0     = ra_r;
    rf_a1     = rb_r;
    rf_we     = 1'b0;
    rf_wa     = ex_wreg;
    rf_wd     = ex_wval;
    dm_we     = 1'b0;
    dm_re     = 1'b0;
    dm_wa     = addr33[AW-1:0];
    dm_wd     = rd0_q;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        dm_we = 1'b1;
        dm_wa = clr_r;
        dm_wd = '0;
      end
      ST_IDLE: in_stall = 1'b0;
      ST_RDD:  rf_a0 = rd_r;
      ST_EXEC: begin
        rf_we     = ex_wr && (op_r != OP_LW);
        dm_we     = ex_mw;
        dm_re     = (op_r == OP_LW) && addr_ok;
        // Dividend is the dest_reg operand, divisor the src_a operand.
        div_start = (op_r == OP_DIV) && (va_r != '0);
      end
      ST_MEMRD: begin
        rf_we = 1'b1;
        rf_wa = rd_r;
        rf_wd = dm_q;
      end
      ST_DONE: out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  // The execute step: the ALU, shift, branch, jump and address operations on the fetched operands.
  // During EXEC va_r holds src_a, vb_r src_b and rd0_q the dest_reg operand; the divider
  // takes rd0_q and va_r directly when it starts.
  assign imm32   = {{16{imm_r[15]}}, imm_r};
  assign addr33  = {va_r[31], va_r} + {imm32[31], imm32};
  assign addr_ok = addr33 < 33'(MEM_WORDS);
  assign idx_inc = idx_r + 1'b1;
  assign prod    = 64'($signed(rd0_q) * $signed(va_r));
  assign rot     = {va_r, va_r} >> sh_r;

  always_comb begin
    ex_status = STAT_OK;
    ex_wr     = 1'b0;
    ex_wreg   = rd_r;
    ex_wval   = '0;
    ex_mw     = 1'b0;
    ex_maddr  = '0;
    taken     = 1'b0;
    ex_next   = idx_inc;
    case (op_r)
      OP_ADD:  begin ex_wr = 1'b1; ex_wval = va_r + vb_r; end
      OP_ADDI: begin ex_wr = 1'b1; ex_wval = va_r + imm32; end
      OP_AND:  begin ex_wr = 1'b1; ex_wval = va_r & vb_r; end
      OP_OR:   begin ex_wr = 1'b1; ex_wval = va_r | vb_r; end
      OP_XOR:  begin ex_wr = 1'b1; ex_wval = va_r ^ vb_r; end
      OP_SUB:  begin ex_wr = 1'b1; ex_wval = va_r - vb_r; end
      OP_SLT:  begin ex_wr = 1'b1; ex_wval = 32'($signed(va_r) < $signed(vb_r)); end
      OP_SLL:  begin ex_wr = 1'b1; ex_wval = va_r << sh_r; end
      OP_SRL:  begin ex_wr = 1'b1; ex_wval = va_r >> sh_r; end
      OP_ROTR: begin ex_wr = 1'b1; ex_wval = rot[31:0]; end
      OP_LUI:  begin ex_wr = 1'b1; ex_wval = {imm_r, 16'd0}; end
      OP_MFHI: begin ex_wr = 1'b1; ex_wval = hi_r; end
      OP_MFLO: begin ex_wr = 1'b1; ex_wval = lo_r; end
      OP_BEQ:  taken = (rd0_q == va_r);
      OP_BNE:  taken = (rd0_q != va_r);
      OP_BGTZ: taken = ($signed(rd0_q) > 0);
      OP_BLEZ: taken = ($signed(rd0_q) <= 0);
      OP_J:    ex_next = IB'(32'(tgt_r)) + 1'b1;
      OP_JAL: begin
        ex_wr   = 1'b1;
        ex_wreg = 5'(RETURN_REG);
        ex_wval = 32'(idx_r);
        ex_next = IB'(32'(tgt_r)) + 1'b1;
      end
      OP_JR:   ex_next = IB'(rd0_q) + 1'b1;
      OP_MULT: ;
      OP_DIV:  if (va_r == '0) ex_status = STAT_DIV0;
      OP_LW: begin
        ex_maddr = addr33[9:0];
        if (addr_ok) begin
          ex_wr = 1'b1;
        end else begin
          ex_status = STAT_ADDR;
        end
      end
      OP_SW: begin
        ex_maddr = addr33[9:0];
        ex_wreg  = '0;
        if (addr_ok) begin
          ex_mw   = 1'b1;
          ex_wval = rd0_q;
        end else begin
          ex_status = STAT_ADDR;
        end
      end
      default: ex_status = STAT_BADOP;
    endcase
    if (!ex_wr) ex_wreg = '0;
    if (taken) ex_next = idx_inc + IB'(imm32);
  end

  // Control and architectural state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      rf_vld_r    <= '0;
      idx_r       <= '0;
      hi_r        <= '0;
      lo_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (rf_we) rf_vld_r[rf_wa] <= 1'b1;
      if (state_r == ST_EXEC) begin
        idx_r <= ex_next;
        if (op_r == OP_MULT) begin
          hi_r <= prod[63:32];
          lo_r <= prod[31:0];
        end
      end
      if (state_r == ST_DIV && div_done) begin
        lo_r <= div_q;
        hi_r <= div_r;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      op_r  <= op_t'(in_func);
      rd_r  <= in_dest_reg;
      ra_r  <= in_src_a;
      rb_r  <= in_src_b;
      imm_r <= in_immediate;
      sh_r  <= in_shift_amount;
      tgt_r <= in_jump_target;
    end
    if (state_r == ST_RDD) begin
      va_r <= rd0_q;
      vb_r <= rd1_q;
    end
    if (state_r == ST_EXEC) begin
      res_next_r   <= 16'(32'(ex_next));
      res_status_r <= ex_status;
      res_wr_r     <= ex_wr;
      res_wreg_r   <= ex_wreg;
      res_wval_r   <= ex_wval;
      res_mw_r     <= ex_mw;
      res_maddr_r  <= ex_maddr;
    end
    if (state_r == ST_MEMRD) res_wval_r <= dm_q;
    if (out_load) begin
      out_next_index    <= res_next_r;
      out_status        <= res_status_r;
      out_reg_written   <= res_wr_r;
      out_written_reg   <= res_wreg_r;
      out_written_value <= res_wval_r;
      out_mem_written   <= res_mw_r;
      out_mem_address   <= res_maddr_r;
    end
  end

  // Register file storage and read ports.
  always_ff @(posedge clk) begin
    if (rf_we) rf[rf_wa] <= rf_wd;
    rd0_q <= rf_vld_r[rf_a0] ? rf[rf_a0] : '0;
    rd1_q <= rf_vld_r[rf_a1] ? rf[rf_a1] : '0;
  end

  // Data memory storage and read port.
  always_ff @(posedge clk) begin
    if (dm_we) dm[dm_wa] <= dm_wd;
    if (dm_re) dm_q <= dm[addr33[AW-1:0]];
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: dv/mips_subset_execute_unit_core_tb.sv
`timescale 1ns / 1ps

module mips_subset_execute_unit_core_tb;
  import mseu_pkg::*;

  localparam int unsigned MEM_WORDS  = 1024;
  localparam int unsigned RETURN_REG = 31;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Instruction channel, driven by the sender.
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [4:0]  in_func = '0;
  logic [4:0]  in_dest_reg = '0;
  logic [4:0]  in_src_a = '0;
  logic [4:0]  in_src_b = '0;
  logic signed [15:0] in_immediate = '0;
  logic [4:0]  in_shift_amount = '0;
  logic [15:0] in_jump_target = '0;

  // Result channel, sampled by the checker.
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_next_index;
  logic [1:0]  out_status;
  logic        out_reg_written;
  logic [4:0]  out_written_reg;
  logic signed [31:0] out_written_value;
  logic        out_mem_written;
  logic [9:0]  out_mem_address;

  mips_subset_execute_unit_core i_dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_func, .in_dest_reg, .in_src_a, .in_src_b,
    .in_immediate, .in_shift_amount, .in_jump_target,
    .out_valid, .out_stall, .out_next_index, .out_status, .out_reg_written,
    .out_written_reg, .out_written_value, .out_mem_written, .out_mem_address
  );

  // One instruction result as the execute unit reports it.
  typedef struct packed {
    logic [15:0] next_index;
    logic [1:0]  status;
    logic        reg_written;
    logic [4:0]  written_reg;
    logic [31:0] written_value;
    logic        mem_written;
    logic [9:0]  mem_address;
  } exec_result_t;

  // Architectural state mirrored by the predictor.
  logic [31:0] arch_regs [32];
  logic [31:0] arch_hi;
  logic [31:0] arch_lo;
  logic [15:0] arch_index;
  logic [31:0] arch_mem [MEM_WORDS];

  exec_result_t pending_results[$];
  int error_count = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit quiet_mode = 1'b0;

  // Computes the result of one instruction and updates the mirrored state.
  function automatic exec_result_t execute_instr(logic [4:0] op, logic [4:0] rd,
      logic [4:0] ra, logic [4:0] rb, logic [15:0] imm16, logic [4:0] sh,
      logic [15:0] tgt);
    exec_result_t r;
    logic [31:0] va, vb, vd, imm;
    logic [15:0] nxt;
    logic taken;
    longint addr, prod;
    r = '0;
    va = arch_regs[ra];
    vb = arch_regs[rb];
    vd = arch_regs[rd];
    imm = {{16{imm16[15]}}, imm16};
    nxt = arch_index + 16'd1;
    taken = 1'b0;
    r.status = STAT_OK;
    case (op)
      OP_ADD:  begin r.reg_written = 1; r.written_reg = rd; r.written_value = va + vb; end
      OP_ADDI: begin r.reg_written = 1; r.written_reg = rd; r.written_value = va + imm; end
      OP_AND:  begin r.reg_written = 1; r.written_reg = rd; r.written_value = va & vb; end
      OP_OR:   begin r.reg_written = 1; r.written_reg = rd; r.written_value = va | vb; end
      OP_XOR:  begin r.reg_written = 1; r.written_reg = rd; r.written_value = va ^ vb; end
      OP_SUB:  begin r.reg_written = 1; r.written_reg = rd; r.written_value = va - vb; end
      OP_SLT: begin
        r.reg_written = 1; r.written_reg = rd;
        r.written_value = ($signed(va) < $signed(vb)) ? 32'd1 : 32'd0;
      end
      OP_SLL:  begin r.reg_written = 1; r.written_reg = rd; r.written_value = va << sh; end
      OP_SRL:  begin r.reg_written = 1; r.written_reg = rd; r.written_value = va >> sh; end
      OP_ROTR: begin
        r.reg_written = 1; r.written_reg = rd;
        r.written_value = (sh == 0) ? va : ((va >> sh) | (va << (6'd32 - sh)));
      end
      OP_LUI: begin
        r.reg_written = 1; r.written_reg = rd; r.written_value = {imm16, 16'h0000};
      end
      OP_BEQ:  taken = (vd == va);
      OP_BNE:  taken = (vd != va);
      OP_BGTZ: taken = ($signed(vd) > 0);
      OP_BLEZ: taken = ($signed(vd) <= 0);
      OP_J:    nxt = tgt + 16'd1;
      OP_JAL: begin
        r.reg_written = 1; r.written_reg = RETURN_REG[4:0];
        r.written_value = {16'h0000, arch_index};
        nxt = tgt + 16'd1;
      end
      OP_JR:   nxt = vd[15:0] + 16'd1;
      OP_MFHI: begin r.reg_written = 1; r.written_reg = rd; r.written_value = arch_hi; end
      OP_MFLO: begin r.reg_written = 1; r.written_reg = rd; r.written_value = arch_lo; end
      OP_MULT: begin
        prod = longint'($signed(vd)) * longint'($signed(va));
        arch_lo = prod[31:0];
        arch_hi = prod[63:32];
      end
      OP_DIV: begin
        if (va == 0) begin
          r.status = STAT_DIV0;
        end else begin
          // Done in 64 bits so the most negative value over minus one stays defined.
          arch_lo = 32'(longint'($signed(vd)) / longint'($signed(va)));
          arch_hi = 32'(longint'($signed(vd)) % longint'($signed(va)));
        end
      end
      OP_LW, OP_SW: begin
        addr = longint'($signed(va)) + longint'($signed(imm));
        r.mem_address = addr[9:0];
        if (addr < 0 || addr >= MEM_WORDS) begin
          r.status = STAT_ADDR;
        end else if (op == OP_LW) begin
          r.reg_written = 1; r.written_reg = rd; r.written_value = arch_mem[addr];
        end else begin
          r.mem_written = 1; r.written_value = vd; arch_mem[addr] = vd;
        end
      end
      default: r.status = STAT_BADOP;
    endcase
    if (taken) nxt = arch_index + 16'd1 + imm16;
    if (r.reg_written) arch_regs[r.written_reg] = r.written_value;
    arch_index = nxt;
    r.next_index = nxt;
    return r;
  endfunction

  // Sends one instruction, with an optional idle burst ahead of it, and
  // records its expected result once the transfer has happened.
  task automatic send_instr(logic [4:0] op, logic [4:0] rd, logic [4:0] ra,
      logic [4:0] rb, logic [15:0] imm16, logic [4:0] sh, logic [15:0] tgt);
    int gap;
    gap = (!quiet_mode && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= op;
    in_dest_reg <= rd;
    in_src_a <= ra;
    in_src_b <= rb;
    in_immediate <= imm16;
    in_shift_amount <= sh;
    in_jump_target <= tgt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(execute_instr(op, rd, ra, rb, imm16, sh, tgt));
  endtask

  // Drops valid and waits for every outstanding result.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stall bursts, and a check of each result transfer.
  always @(posedge clk) begin
    exec_result_t got, want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_next_index, out_status, out_reg_written, out_written_reg,
             out_written_value, out_mem_written, out_mem_address};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, got);
          if (got.next_index !== want.next_index)
            $display("%0t:   next_index expected %h actual %h", $time,
                     want.next_index, got.next_index);
          if (got.status !== want.status)
            $display("%0t:   status expected %0d actual %0d", $time, want.status, got.status);
          if (got.reg_written !== want.reg_written || got.written_reg !== want.written_reg)
            $display("%0t:   register write expected %b/%0d actual %b/%0d", $time,
                     want.reg_written, want.written_reg, got.reg_written, got.written_reg);
          if (got.written_value !== want.written_value)
            $display("%0t:   written_value expected %h actual %h", $time,
                     want.written_value, got.written_value);
          if (got.mem_written !== want.mem_written || got.mem_address !== want.mem_address)
            $display("%0t:   memory expected %b/%h actual %b/%h", $time,
                     want.mem_written, want.mem_address, got.mem_written, got.mem_address);
          error_count++;
        end
      end
    end
    // Stall bursts of random length, none started in quiet mode.
    if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      stall_left <= int'($urandom_range(1, 3));
      out_stall <= 1'b1;
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_directed_alu();
    // Build extreme register contents: max positive, min negative, all ones.
    send_instr(OP_LUI, 1, 0, 0, 16'h7FFF, 0, 0);
    send_instr(OP_ADDI, 1, 1, 0, 16'h7FFF, 0, 0);
    send_instr(OP_ADDI, 1, 1, 0, 16'h7FFF, 0, 0);
    send_instr(OP_ADDI, 1, 1, 0, 16'h0001, 0, 0);
    send_instr(OP_LUI, 2, 0, 0, 16'h8000, 0, 0);
    send_instr(OP_ADDI, 3, 0, 0, 16'hFFFF, 0, 0);
    // Signed overflow wraps on ADD and SUB.
    send_instr(OP_ADD, 4, 1, 3, 0, 0, 0);
    send_instr(OP_ADD, 5, 1, 1, 0, 0, 0);
    send_instr(OP_SUB, 6, 2, 1, 0, 0, 0);
    send_instr(OP_AND, 7, 1, 3, 0, 0, 0);
    send_instr(OP_OR, 8, 1, 2, 0, 0, 0);
    send_instr(OP_XOR, 9, 3, 2, 0, 0, 0);
    send_instr(OP_SLT, 10, 2, 1, 0, 0, 0);
    send_instr(OP_SLT, 11, 1, 2, 0, 0, 0);
    // Shifts at the top of the distance range, rotates at both ends; SRL is logical.
    send_instr(OP_SLL, 12, 3, 0, 0, 5'd31, 0);
    send_instr(OP_SRL, 13, 2, 0, 0, 5'd31, 0);
    send_instr(OP_ROTR, 14, 1, 0, 0, 5'd0, 0);
    send_instr(OP_ROTR, 15, 8, 0, 0, 5'd1, 0);
    send_instr(OP_ROTR, 16, 8, 0, 0, 5'd31, 0);
    send_instr(OP_LUI, 0, 0, 0, 16'hFFFF, 0, 0);   // register zero is writable
    send_instr(OP_ADD, 17, 0, 0, 0, 0, 0);
    send_instr(5'd24, 1, 2, 3, 16'h1234, 5, 16'h5555);
    send_instr(5'd31, 31, 31, 31, 16'hFFFF, 31, 16'hFFFF);
    drain_results();
  endtask

  task automatic test_directed_muldiv();
    send_instr(OP_MULT, 2, 2, 0, 0, 0, 0);        // most negative squared
    send_instr(OP_MFHI, 18, 0, 0, 0, 0, 0);
    send_instr(OP_MFLO, 19, 0, 0, 0, 0, 0);
    send_instr(OP_DIV, 2, 3, 0, 0, 0, 0);         // division overflow case
    send_instr(OP_MFLO, 18, 0, 0, 0, 0, 0);
    send_instr(OP_MFHI, 19, 0, 0, 0, 0, 0);
    send_instr(OP_ADDI, 20, 0, 0, 16'hFFF9, 0, 0);
    send_instr(OP_ADDI, 21, 0, 0, 16'h0002, 0, 0);
    send_instr(OP_DIV, 20, 21, 0, 0, 0, 0);       // truncates toward zero
    send_instr(OP_MFHI, 22, 0, 0, 0, 0, 0);
    send_instr(OP_LUI, 23, 0, 0, 16'h0000, 0, 0);
    send_instr(OP_DIV, 20, 23, 0, 0, 0, 0);       // divide by zero keeps HI and LO
    send_instr(OP_MFLO, 24, 0, 0, 0, 0, 0);
    drain_results();
  endtask

  task automatic test_directed_memory_flow();
    send_instr(OP_ADDI, 25, 0, 0, 16'd1000, 0, 0);
    send_instr(OP_SW, 1, 25, 0, 16'd23, 0, 0);    // last word
    send_instr(OP_LW, 26, 25, 0, 16'd23, 0, 0);
    send_instr(OP_SW, 1, 25, 0, 16'd24, 0, 0);    // one past the end
    send_instr(OP_LW, 26, 23, 0, 16'hFFFF, 0, 0); // negative address
    send_instr(OP_LW, 26, 23, 0, 16'd0, 0, 0);    // first word, never written
    send_instr(OP_SW, 2, 2, 0, 16'h7FFF, 0, 0);   // far out of range
    send_instr(OP_BEQ, 23, 23, 0, 16'h8000, 0, 0);
    send_instr(OP_BNE, 1, 2, 0, 16'h7FFF, 0, 0);
    send_instr(OP_BGTZ, 1, 0, 0, 16'hFFFE, 0, 0);
    send_instr(OP_BGTZ, 23, 0, 0, 16'h0005, 0, 0);
    send_instr(OP_BLEZ, 2, 0, 0, 16'h0003, 0, 0);
    send_instr(OP_BLEZ, 23, 0, 0, 16'h0003, 0, 0);
    send_instr(OP_JAL, 0, 0, 0, 0, 0, 16'hFFFF);
    send_instr(OP_J, 0, 0, 0, 0, 0, 16'h1234);
    send_instr(OP_JAL, 0, 0, 0, 0, 0, 16'h0000);
    send_instr(OP_JR, RETURN_REG[4:0], 0, 0, 0, 0, 0);
    send_instr(OP_JR, 3, 0, 0, 0, 0, 0);
    drain_results();
  endtask

  // Random instruction mix: mostly legal ops with a small share of unknown
  // codes, memory addresses steered into range most of the time.
  task automatic test_random_mix(int count);
    logic [4:0] op, rd, ra;
    logic [15:0] imm16;
    for (int n = 0; n < count; n++) begin
      op = ($urandom_range(0, 30) == 0) ? 5'($urandom_range(24, 31))
                                        : 5'($urandom_range(0, 23));
      rd = 5'($urandom);
      ra = 5'($urandom);
      imm16 = 16'($urandom);
      if ((op == OP_LW || op == OP_SW) && $urandom_range(0, 4) != 0) begin
        // Point the base register at a valid word first.
        send_instr(OP_ADDI, ra, 0, 0, 16'($urandom_range(0, MEM_WORDS - 1)), 0, 0);
        imm16 = 16'($signed(5'($urandom)));
      end
      if (op == OP_DIV && $urandom_range(0, 3) == 0) ra = 0;
      send_instr(op, rd, ra, 5'($urandom), imm16, 5'($urandom), 16'($urandom));
      if (n == count / 2) drain_results();
    end
    drain_results();
  endtask

  initial begin
    foreach (arch_regs[i]) arch_regs[i] = '0;
    foreach (arch_mem[i]) arch_mem[i] = '0;
    arch_hi = '0;
    arch_lo = '0;
    arch_index = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_alu();
    test_directed_muldiv();
    test_directed_memory_flow();
    test_random_mix(1300);
    // Final stretch with no idling on either side.
    quiet_mode = 1'b1;
    test_random_mix(300);
    repeat (60) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
